@@ hdl/sddd_pkg.sv @@
// ----------------------------------------------------------------------------
// sddd_pkg: shared types and constants for the signed decimal display
// Position codes and clamp limits used by the six-digit display encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sddd_pkg;

  localparam int CODE_W = 5;
  localparam int MAG_W  = 20;
  localparam int PART_W = 10;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [3:0]        bcd_t;
  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [PART_W-1:0] part_t;

  localparam code_t CODE_ZERO  = 5'd0;
  localparam code_t CODE_MINUS = 5'd16;
  localparam code_t CODE_BLANK = 5'd17;

  localparam logic signed [31:0] MAX_SHOWN = 32'sd999999;
  localparam logic signed [31:0] MIN_SHOWN = -32'sd9999;
  localparam mag_t               MAX_MAG   = 20'd999999;
  localparam mag_t               MIN_MAG   = 20'd9999;

  // floor(mag / 1000) estimate: (mag * 1048) >> 20 is low by at most one
  localparam logic [10:0] RCP_1000 = 11'd1048;
  // exact for values below 1000: (x * 41) >> 12 = x / 100
  localparam logic [5:0]  RCP_100  = 6'd41;
  // exact for values below 100: (x * 205) >> 11 = x / 10
  localparam logic [7:0]  RCP_10   = 8'd205;

endpackage : sddd_pkg

`default_nettype wire

@@ hdl/signed_decimal_digit_display.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_digit_display: six-position signed decimal display encoder
// Clamps a signed 32-bit value to -9999..999999 and emits six position codes
// (digit, minus, blank), least significant position first.
//
//   channel  ports                          handshake
//   -------  -----------------------------  ------------------------------
//   input    start, busy, in_value          taken when start && !busy
//   result   out_valid, out_digit0..5       one-cycle strobe, no stall
//
// Seven-stage pipeline: the result strobes after the transaction has passed
// through every stage, and a new transaction is taken every cycle; busy is always low.
// The stages follow the chain of constant-reciprocal divisions (by 1000,
// then by 100, then by 10).
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_digit_display (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  signed [31:0]  in_value,
  output logic                out_valid,
  output sddd_pkg::code_t     out_digit0,
  output sddd_pkg::code_t     out_digit1,
  output sddd_pkg::code_t     out_digit2,
  output sddd_pkg::code_t     out_digit3,
  output sddd_pkg::code_t     out_digit4,
  output sddd_pkg::code_t     out_digit5
);

  import sddd_pkg::*;

  localparam int STAGES = 7;

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;

  // stage 1: input register
  logic signed [31:0] value_r;

  // stage 2: clamp and magnitude
  logic        neg2_r, neg2_nxt;
  mag_t        mag2_r, mag2_nxt;
  logic [31:0] negated;

  // stage 3: reciprocal product for / 1000
  logic        neg3_r;
  mag_t        mag3_r;
  logic [29:0] prod3_r, prod3_nxt;

  // stage 4: thousands split
  logic        neg4_r;
  part_t       hi4_r, hi4_nxt;
  part_t       lo4_r, lo4_nxt;
  part_t       q_est;
  logic [19:0] q_times;
  logic [10:0] rem_est;

  // stage 5: hundreds split
  logic        neg5_r;
  bcd_t        hh5_r, hh5_nxt, lh5_r, lh5_nxt;
  logic [6:0]  hr5_r, hr5_nxt, lr5_r, lr5_nxt;
  logic [15:0] hp100, lp100;

  // stage 6: tens and units
  logic        neg6_r;
  bcd_t        dig6_r [6];
  bcd_t        dig6_nxt [6];
  logic [14:0] hp10, lp10;
  bcd_t        ht, lt;

  // stage 7: formatting
  code_t       code_r [6];
  code_t       code_nxt [6];
  logic [5:0]  show;

  assign busy = 1'b0;

  assign vld_nxt = {vld_r[STAGES-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 2
  always_comb begin
    negated = 32'd0 - 32'(value_r);
    if (value_r > MAX_SHOWN) begin
      neg2_nxt = 1'b0;
      mag2_nxt = MAX_MAG;
    end else if (value_r < MIN_SHOWN) begin
      neg2_nxt = 1'b1;
      mag2_nxt = MIN_MAG;
    end else if (value_r[31]) begin
      neg2_nxt = 1'b1;
      mag2_nxt = negated[MAG_W-1:0];
    end else begin
      neg2_nxt = 1'b0;
      mag2_nxt = value_r[MAG_W-1:0];
    end
  end

  // stage 3
  always_comb begin
    prod3_nxt = 30'(mag2_r) * 30'(RCP_1000);
  end

  // stage 4
  always_comb begin
    q_est   = prod3_r[29:20];
    q_times = 20'(q_est) * 20'd1000;
    rem_est = 11'(mag3_r - q_times);
    if (rem_est >= 11'd1000) begin
      hi4_nxt = q_est + 10'd1;
      lo4_nxt = 10'(rem_est - 11'd1000);
    end else begin
      hi4_nxt = q_est;
      lo4_nxt = rem_est[PART_W-1:0];
    end
  end

  // stage 5
  always_comb begin
    hp100   = 16'(hi4_r) * 16'(RCP_100);
    lp100   = 16'(lo4_r) * 16'(RCP_100);
    hh5_nxt = hp100[15:12];
    lh5_nxt = lp100[15:12];
    hr5_nxt = 7'(hi4_r - 10'(hh5_nxt) * 10'd100);
    lr5_nxt = 7'(lo4_r - 10'(lh5_nxt) * 10'd100);
  end

  // stage 6
  always_comb begin
    hp10 = 15'(hr5_r) * 15'(RCP_10);
    lp10 = 15'(lr5_r) * 15'(RCP_10);
    ht   = hp10[14:11];
    lt   = lp10[14:11];
    dig6_nxt[0] = 4'(lr5_r - 7'(lt) * 7'd10);
    dig6_nxt[1] = lt;
    dig6_nxt[2] = lh5_r;
    dig6_nxt[3] = 4'(hr5_r - 7'(ht) * 7'd10);
    dig6_nxt[4] = ht;
    dig6_nxt[5] = hh5_r;
  end

  // stage 7: a position shows a digit if it or any higher one is nonzero;
  // position 0 always shows its digit so zero reads as a single 0
  always_comb begin
    show[5] = (dig6_r[5] != 4'd0);
    for (int k = 4; k >= 0; k--) begin
      show[k] = show[k+1] || (dig6_r[k] != 4'd0);
    end
    show[0] = 1'b1;
    code_nxt[0] = {1'b0, dig6_r[0]};
    for (int k = 1; k < 6; k++) begin
      if (show[k]) begin
        code_nxt[k] = {1'b0, dig6_r[k]};
      end else if (neg6_r && show[k-1]) begin
        code_nxt[k] = CODE_MINUS;
      end else begin
        code_nxt[k] = CODE_BLANK;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= in_value;
    neg2_r  <= neg2_nxt;
    mag2_r  <= mag2_nxt;
    neg3_r  <= neg2_r;
    mag3_r  <= mag2_r;
    prod3_r <= prod3_nxt;
    neg4_r  <= neg3_r;
    hi4_r   <= hi4_nxt;
    lo4_r   <= lo4_nxt;
    neg5_r  <= neg4_r;
    hh5_r   <= hh5_nxt;
    lh5_r   <= lh5_nxt;
    hr5_r   <= hr5_nxt;
    lr5_r   <= lr5_nxt;
    neg6_r  <= neg5_r;
    dig6_r  <= dig6_nxt;
    code_r  <= code_nxt;
  end

  assign out_valid  = vld_r[STAGES-1];
  assign out_digit0 = code_r[0];
  assign out_digit1 = code_r[1];
  assign out_digit2 = code_r[2];
  assign out_digit3 = code_r[3];
  assign out_digit4 = code_r[4];
  assign out_digit5 = code_r[5];

endmodule : signed_decimal_digit_display

`default_nettype wire
